// ===== hw/rtl/sipq_pkg.sv =====
`timescale 1ns / 1ps
package sipq_pkg;

    localparam int DATA_W = 32;
    localparam int PRIO_W = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W = 4;

    // operation codes carried on s_tuser
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // result word layout, lowest bit up
    localparam int RES_STATUS_LSB = 0;
    localparam int RES_DATA_LSB = RES_STATUS_LSB + STATUS_W;
    localparam int RES_PRIO_LSB = RES_DATA_LSB + DATA_W;
    localparam int RES_OCC_LSB = RES_PRIO_LSB + PRIO_W;
    localparam int RES_BITS = RES_OCC_LSB + OCC_W;
    localparam int RES_W = ((RES_BITS + 7) / 8) * 8;

    localparam int ITEM_W = DATA_W + PRIO_W;

    typedef struct packed {
        logic signed [PRIO_W-1:0] prio;
        logic signed [DATA_W-1:0] data;
    } entry_t;

    typedef struct packed {
        logic enq;       // enqueue that will be stored
        logic deq;       // dequeue of a stored entry
        logic occupied;  // this cell holds a live entry
        logic at_tail;   // first free cell
        logic left_ins;  // left neighbour is pushing its entry into this cell
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/sipq_cell.sv =====
`timescale 1ns / 1ps
module sipq_cell
    import sipq_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  entry_t     item,
    input  entry_t     left_entry,
    input  entry_t     right_entry,
    output entry_t     entry,
    output logic       ins
);

    entry_t entry_reg;
    entry_t entry_next;

    // new item goes in front of this entry
    assign ins = ctrl.occupied && (item.prio < entry_reg.prio);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.deq)
        begin
            entry_next = right_entry;
        end
        else if (ctrl.enq)
        begin
            if (ctrl.left_ins)
            begin
                entry_next = left_entry;
            end
            else if (ins || ctrl.at_tail)
            begin
                entry_next = item;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== hw/rtl/sorted_insert_priority_queue.sv =====
`timescale 1ns / 1ps
// the result word of an accepted input word is registered onto m_tdata
// throughput: one word per cycle unless the output stalls; every cell compares the new
// priority in parallel, and entries move one place along the row in the same cycle
// reset: rst_n clears the entry count and the output valid; cell contents stay
// undefined until written and are never read before then
module sorted_insert_priority_queue
    import sipq_pkg::*;
#(
    parameter int CAPACITY = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [ITEM_W-1:0] s_tdata,   // item_data, item_priority
    input  logic [0:0]        s_tuser,   // operation
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [RES_W-1:0]  m_tdata    // status, head_data, head_priority, occupancy
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             m_tvalid_reg;
    logic [RES_W-1:0] m_tdata_reg;
    logic [RES_W-1:0] res_word;

    logic   accept;
    logic   is_deq;
    logic   full;
    logic   empty;
    logic   do_enq;
    logic   do_deq;
    entry_t item;

    entry_t     cell_entry [CAPACITY];
    logic       cell_ins [CAPACITY];
    cell_ctrl_t cell_ctrl [CAPACITY];

    logic [STATUS_W-1:0] res_status;
    entry_t              res_head;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept = s_tvalid && s_tready;
    assign is_deq = (s_tuser[0] == OP_DEQUEUE);
    assign full = (count_reg == CNT_W'(CAPACITY));
    assign empty = (count_reg == '0);
    assign do_enq = accept && !is_deq && !full;
    assign do_deq = accept && is_deq && !empty;

    assign item.data = s_tdata[DATA_W-1:0];
    assign item.prio = s_tdata[DATA_W +: PRIO_W];

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        entry_t left_e;
        entry_t right_e;

        if (i == 0)
        begin : g_first
            assign left_e = item;
            assign cell_ctrl[i].left_ins = 1'b0;
        end
        else
        begin : g_mid
            assign left_e = cell_entry[i-1];
            assign cell_ctrl[i].left_ins = cell_ins[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_e = cell_entry[i];
        end
        else
        begin : g_inner
            assign right_e = cell_entry[i+1];
        end

        assign cell_ctrl[i].enq = do_enq;
        assign cell_ctrl[i].deq = do_deq;
        assign cell_ctrl[i].occupied = (CNT_W'(i) < count_reg);
        assign cell_ctrl[i].at_tail = (CNT_W'(i) == count_reg);

        sipq_cell u_cell (
            .clk         (clk),
            .ctrl        (cell_ctrl[i]),
            .item        (item),
            .left_entry  (left_e),
            .right_entry (right_e),
            .entry       (cell_entry[i]),
            .ins         (cell_ins[i])
        );
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_enq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_deq)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_comb
    begin
        res_status = ST_OK;
        res_head = '0;
        if (is_deq)
        begin
            if (empty)
            begin
                res_status = ST_EMPTY;
            end
            else
            begin
                res_head = cell_entry[0];
            end
        end
        else if (full)
        begin
            res_status = ST_FULL;
        end
    end

    always_comb
    begin
        res_word = '0;
        res_word[RES_STATUS_LSB +: STATUS_W] = res_status;
        res_word[RES_DATA_LSB +: DATA_W] = res_head.data;
        res_word[RES_PRIO_LSB +: PRIO_W] = res_head.prio;
        res_word[RES_OCC_LSB +: OCC_W] = OCC_W'(count_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_tdata_reg <= res_word;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;

endmodule

// ===== hw/rtl/sipq_checker.sv =====
`timescale 1ns / 1ps
module sipq_checker
    import sipq_pkg::*;
#(
    parameter int CAPACITY = 8
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [RES_W-1:0] m_tdata
);

    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   head_data;
    logic [PRIO_W-1:0]   head_prio;
    logic [OCC_W-1:0]    occupancy;

    assign status = m_tdata[RES_STATUS_LSB +: STATUS_W];
    assign head_data = m_tdata[RES_DATA_LSB +: DATA_W];
    assign head_prio = m_tdata[RES_PRIO_LSB +: PRIO_W];
    assign occupancy = m_tdata[RES_OCC_LSB +: OCC_W];

    // a word waiting at the output stays there until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word dropped or changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (status == ST_OK || status == ST_FULL || status == ST_EMPTY))
        else $error("undefined status code");

    // empty dequeue reports nothing stored and a zero head
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && status == ST_EMPTY |->
            occupancy == '0 && head_data == '0 && head_prio == '0)
        else $error("empty status with stored entries or nonzero head");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && status == ST_FULL |->
            occupancy == OCC_W'(CAPACITY) && head_data == '0 && head_prio == '0)
        else $error("full status with wrong occupancy or nonzero head");

    a_occ_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && CAPACITY < 16 |-> 32'(occupancy) <= 32'(CAPACITY))
        else $error("occupancy above capacity");

endmodule

bind sorted_insert_priority_queue sipq_checker #(.CAPACITY(CAPACITY)) u_sipq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== bench/sorted_insert_priority_queue_checker.sv =====
`timescale 1ns / 1ps
module sorted_insert_priority_queue_checker
    import sipq_pkg::*;
#(
    parameter int CAPACITY = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [ITEM_W-1:0] s_tdata,   // item_data, item_priority
    input  logic [0:0]        s_tuser,   // operation
    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [RES_W-1:0]  m_tdata,   // status, head_data, head_priority, occupancy
    output int                mismatches,
    output int                pending,
    output int                results_seen,
    output int                full_seen,
    output int                empty_seen,
    output int                served_seen
);

    localparam int PRINT_CAP = 40;

    typedef struct {
        logic [STATUS_W-1:0]      status;
        logic signed [DATA_W-1:0] head_data;
        logic signed [PRIO_W-1:0] head_prio;
        logic [OCC_W-1:0]         occupancy;
        logic                     served;
    } queue_result_t;

    // own copy of the sorted store
    logic signed [DATA_W-1:0] store_data [CAPACITY];
    logic signed [PRIO_W-1:0] store_prio [CAPACITY];
    int                       store_count;

    queue_result_t expected_results[$];
    queue_result_t got;
    queue_result_t want;

    function automatic queue_result_t apply_operation(logic op, logic signed [DATA_W-1:0] data,
                                                      logic signed [PRIO_W-1:0] prio);
        queue_result_t r;
        int            pos;
        r.status    = ST_OK;
        r.head_data = '0;
        r.head_prio = '0;
        r.served    = 1'b0;
        if (op == OP_ENQUEUE) begin
            if (store_count >= CAPACITY) begin
                r.status = ST_FULL;
            end
            else begin
                pos = store_count;
                // later arrivals with equal priority land behind the earlier ones
                while (pos > 0 && prio < store_prio[pos-1]) begin
                    store_data[pos] = store_data[pos-1];
                    store_prio[pos] = store_prio[pos-1];
                    pos--;
                end
                store_data[pos] = data;
                store_prio[pos] = prio;
                store_count++;
            end
        end
        else begin
            if (store_count == 0) begin
                r.status = ST_EMPTY;
            end
            else begin
                r.head_data = store_data[0];
                r.head_prio = store_prio[0];
                r.served    = 1'b1;
                for (int i = 1; i < store_count; i++) begin
                    store_data[i-1] = store_data[i];
                    store_prio[i-1] = store_prio[i];
                end
                store_count--;
            end
        end
        r.occupancy = store_count[OCC_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_CAP)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    initial
    begin
        mismatches   = 0;
        pending      = 0;
        results_seen = 0;
        full_seen    = 0;
        empty_seen   = 0;
        served_seen  = 0;
        store_count  = 0;
    end

    always @(posedge clk)
    begin
        if (!rst_n) begin
            store_count = 0;
            expected_results.delete();
        end
        else begin
            if (s_tvalid && s_tready)
                expected_results.push_back(apply_operation(s_tuser[0],
                    s_tdata[DATA_W-1:0], s_tdata[ITEM_W-1:DATA_W]));

            if (m_tvalid && m_tready) begin
                got.status    = m_tdata[RES_STATUS_LSB +: STATUS_W];
                got.head_data = m_tdata[RES_DATA_LSB +: DATA_W];
                got.head_prio = m_tdata[RES_PRIO_LSB +: PRIO_W];
                got.occupancy = m_tdata[RES_OCC_LSB +: OCC_W];
                results_seen++;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result word with nothing expected, status %0d",
                                              got.status));
                end
                else begin
                    want = expected_results.pop_front();
                    if (want.status == ST_FULL)
                        full_seen++;
                    else if (want.status == ST_EMPTY)
                        empty_seen++;
                    else if (want.served)
                        served_seen++;
                    if (got.status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  got.status, want.status));
                    if (got.head_data !== want.head_data)
                        report_mismatch($sformatf("head_data got %0d want %0d",
                                                  got.head_data, want.head_data));
                    if (got.head_prio !== want.head_prio)
                        report_mismatch($sformatf("head_priority got %0d want %0d",
                                                  got.head_prio, want.head_prio));
                    if (got.occupancy !== want.occupancy)
                        report_mismatch($sformatf("occupancy got %0d want %0d",
                                                  got.occupancy, want.occupancy));
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

// ===== bench/sorted_insert_priority_queue_tb.sv =====
`timescale 1ns / 1ps
module sorted_insert_priority_queue_tb;
    import sipq_pkg::*;

    localparam int QUEUE_DEPTH = 8;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 8;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [ITEM_W-1:0] s_tdata;
    logic [0:0]        s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [RES_W-1:0]  m_tdata;

    int mismatches;
    int pending;
    int results_seen;
    int full_seen;
    int empty_seen;
    int served_seen;
    int cycle_count;
    int words_sent;
    int stall_left;
    bit tx_gaps_on;
    bit rx_stalls_on;

    sorted_insert_priority_queue #(
        .CAPACITY (QUEUE_DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sorted_insert_priority_queue_checker #(
        .CAPACITY (QUEUE_DEPTH)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .mismatches   (mismatches),
        .pending      (pending),
        .results_seen (results_seen),
        .full_seen    (full_seen),
        .empty_seen   (empty_seen),
        .served_seen  (served_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("sorted_insert_priority_queue test failed");
            $finish;
        end
    end

    // mostly short stalls, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 24);
    endfunction

    initial
    begin
        m_tready   = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge clk);
            if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end
            else if (rx_stalls_on && $urandom_range(0, 99) < 30) begin
                stall_left = pick_gap();
                m_tready   = (stall_left == 0);
            end
            else begin
                m_tready = 1'b1;
            end
        end
    end

    task automatic send_word(input logic op, input logic [DATA_W-1:0] data,
                             input logic [PRIO_W-1:0] prio);
        int gap;
        gap = tx_gaps_on ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            s_tdata  = {$urandom, $urandom};
            s_tuser  = 1'($urandom);
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {prio, data};
        do @(posedge clk); while (!s_tready);
        words_sent++;
    endtask

    task automatic wait_drained();
        while (pending != 0) @(negedge clk);
    endtask

    // narrow priorities give plenty of ties so the arrival order gets exercised
    task automatic run_random(input int count, input int enq_pct, input bit narrow);
        logic              op;
        logic [PRIO_W-1:0] prio;
        for (int i = 0; i < count; i++) begin
            op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE;
            if (narrow)
                prio = PRIO_W'($signed($urandom_range(0, 6)) - 3);
            else if ($urandom_range(0, 3) == 0)
                prio = PRIO_W'($signed($urandom_range(0, 20)) - 10);
            else
                prio = $urandom;
            send_word(op, $urandom, prio);
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = OP_ENQUEUE;
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        cycle_count  = 0;
        words_sent   = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty pop, extremes, ties, overflow, drain
        send_word(OP_DEQUEUE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(OP_ENQUEUE, 32'h8000_0000, 32'h7FFF_FFFF);
        send_word(OP_ENQUEUE, 32'h7FFF_FFFF, 32'h8000_0000);
        send_word(OP_ENQUEUE, 32'h0000_0001, 32'h0000_0000);
        send_word(OP_ENQUEUE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(OP_ENQUEUE, 32'h0000_0002, 32'h0000_0000);
        send_word(OP_ENQUEUE, 32'h0000_0003, 32'h0000_0000);
        send_word(OP_ENQUEUE, 32'h5555_5555, 32'h7FFF_FFFF);
        send_word(OP_ENQUEUE, 32'hAAAA_AAAA, 32'h8000_0000);
        send_word(OP_ENQUEUE, 32'h1234_5678, 32'h0000_0000);
        for (int i = 0; i < QUEUE_DEPTH; i++)
            send_word(OP_DEQUEUE, $urandom, $urandom);
        send_word(OP_DEQUEUE, 32'h0000_0000, 32'h0000_0000);
        send_word(OP_ENQUEUE, 32'h0000_0000, 32'h0000_0000);
        send_word(OP_DEQUEUE, 32'h0000_0000, 32'h0000_0000);

        // random: balanced, filling, draining, ties, all but one run under back-pressure
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        run_random(150, 50, 1'b0);
        @(negedge clk);
        s_tvalid = 1'b0;
        wait_drained();
        run_random(150, 75, 1'b1);
        tx_gaps_on = 1'b0;
        run_random(100, 30, 1'b0);
        rx_stalls_on = 1'b0;
        run_random(100, 55, 1'b1);
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        run_random(100, 50, 1'b0);
        @(negedge clk);
        s_tvalid = 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d words sent, %0d results checked", words_sent, results_seen);
        $display("%0d full rejects, %0d empty rejects, %0d entries served",
                 full_seen, empty_seen, served_seen);
        if (mismatches == 0) begin
            $display("sorted_insert_priority_queue test passed");
        end
        else begin
            $display("%0d mismatches", mismatches);
            $display("sorted_insert_priority_queue test failed");
        end
        $finish;
    end

endmodule
